@@ design/bmc_pkg.sv @@
// Shared widths, codes and types of the bisulfite methylation caller.
package bmc_pkg;

    localparam int unsigned COUNT_DEPTH = 65536;
    localparam int unsigned CNT_AW      = $clog2(COUNT_DEPTH);

    localparam int unsigned POS_W     = 31;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned QUAL_W    = 8;
    localparam int unsigned FLAG_W    = 12;
    localparam int unsigned STATUS_W  = 5;
    localparam int unsigned STRAND_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 31;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [QUAL_W-1:0] t_qual;

    typedef enum logic [1:0] {
        REQ_HEADER  = 2'd0,
        REQ_BASE    = 2'd1,
        REQ_END     = 2'd2,
        REQ_READOUT = 2'd3
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED      = 5'd0,
        ST_UNMAPPED      = 5'd1,
        ST_SECONDARY     = 5'd2,
        ST_QC_FAIL       = 5'd3,
        ST_DUPLICATE     = 5'd4,
        ST_SUPPLEMENTARY = 5'd5,
        ST_LOW_MAPQ      = 5'd6,
        ST_MULTIMAPPED   = 5'd7,
        ST_METH          = 5'd8,
        ST_UNMETH        = 5'd9,
        ST_NO_CALL       = 5'd10,
        ST_OUTSIDE       = 5'd11,
        ST_CLIPPED       = 5'd12,
        ST_NOT_CYT       = 5'd13,
        ST_LOW_BASEQ     = 5'd14,
        ST_NO_READ       = 5'd15,
        ST_END_UNUSED    = 5'd16,
        ST_END_USED      = 5'd17,
        ST_READOUT       = 5'd18
    } t_status;

    // Bit positions in the SAM flag word.
    localparam int unsigned FLAG_PAIRED    = 0;
    localparam int unsigned FLAG_UNMAP     = 2;
    localparam int unsigned FLAG_MUNMAP    = 3;
    localparam int unsigned FLAG_REVERSE   = 4;
    localparam int unsigned FLAG_READ1     = 6;
    localparam int unsigned FLAG_READ2     = 7;
    localparam int unsigned FLAG_SECONDARY = 8;
    localparam int unsigned FLAG_QCFAIL    = 9;
    localparam int unsigned FLAG_DUP       = 10;
    localparam int unsigned FLAG_SUPPL     = 11;

    localparam logic [1:0] CONV_CT = 2'd1;
    localparam logic [1:0] CONV_GA = 2'd2;

    localparam logic [1:0] REF_C = 2'd1;
    localparam logic [1:0] REF_G = 2'd2;

    localparam logic [3:0] NT_A = 4'd1;
    localparam logic [3:0] NT_C = 4'd2;
    localparam logic [3:0] NT_G = 4'd4;
    localparam logic [3:0] NT_T = 4'd8;

    localparam logic [1:0] TAG_METH   = 2'd1;
    localparam logic [1:0] TAG_UNMETH = 2'd2;

    localparam logic [STRAND_W-1:0] STRAND_NONE = 3'd0;
    localparam logic [STRAND_W-1:0] STRAND_1    = 3'd1;
    localparam logic [STRAND_W-1:0] STRAND_2    = 3'd2;
    localparam logic [STRAND_W-1:0] STRAND_3    = 3'd3;
    localparam logic [STRAND_W-1:0] STRAND_4    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAPQ     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BASEQ    = 2'd3;

    typedef enum logic [1:0] {
        CNT_READ       = 2'd0,
        CNT_INC_METH   = 2'd1,
        CNT_INC_UNMETH = 2'd2
    } t_cnt_op;

    typedef struct packed {
        logic              rd;
        t_cnt_op           op;
        logic [CNT_AW-1:0] addr;
    } t_cnt_cmd;

    typedef struct packed {
        logic clear_busy;
        t_cnt meth;
        t_cnt unmeth;
    } t_cnt_rsp;

endpackage

@@ design/bmc_req_if.sv @@
// Request channel of the methylation caller: one read header, base, read end or readout.
interface bmc_req_if import bmc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [FLAG_W-1:0]   sam_flags;
    logic [QUAL_W-1:0]   map_quality;
    logic [7:0]          hit_count;
    logic [1:0]          conversion_tag;
    logic [POS_W-1:0]    ref_position;
    logic [POS_W-1:0]    mate_position;
    logic                mate_same_chrom;
    logic [1:0]          ref_base;
    logic [3:0]          read_base;
    logic [QUAL_W-1:0]   base_quality;
    logic [1:0]          meth_tag_call;

    modport source (
        output valid, req_type, sam_flags, map_quality, hit_count, conversion_tag,
               ref_position, mate_position, mate_same_chrom, ref_base, read_base,
               base_quality, meth_tag_call,
        input  ready
    );

    modport sink (
        input  valid, req_type, sam_flags, map_quality, hit_count, conversion_tag,
               ref_position, mate_position, mate_same_chrom, ref_base, read_base,
               base_quality, meth_tag_call,
        output ready
    );
endinterface

@@ design/bmc_rsp_if.sv @@
// Result channel of the methylation caller: status, strand class and counts.
interface bmc_rsp_if import bmc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [STRAND_W-1:0] read_strand;
    logic [CNT_W-1:0]    meth_count;
    logic [CNT_W-1:0]    unmeth_count;

    modport source (
        output valid, status, read_strand, meth_count, unmeth_count,
        input  ready
    );

    modport sink (
        input  valid, status, read_strand, meth_count, unmeth_count,
        output ready
    );
endinterface

@@ design/bmc_count_store.sv @@
// Per-position methylated and unmethylated counter memories with saturating update.
module bmc_count_store import bmc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cnt_cmd i_cmd,
    output t_cnt_rsp o_rsp
);

    t_cnt r_meth_mem   [COUNT_DEPTH];
    t_cnt r_unmeth_mem [COUNT_DEPTH];

    t_cnt              r_q_meth;
    t_cnt              r_q_unmeth;
    logic              r_pend;
    t_cnt_op           r_op;
    logic [CNT_AW-1:0] r_addr;
    logic              r_clr_busy;
    logic [CNT_AW-1:0] r_clr_addr;

    logic              w_meth_en;
    logic              w_unmeth_en;
    logic [CNT_AW-1:0] w_addr;
    t_cnt              w_meth_data;
    t_cnt              w_unmeth_data;

    // The write back lands in the cycle after the read, when the read data is valid.
    always_comb begin
        w_meth_en     = 1'b0;
        w_unmeth_en   = 1'b0;
        w_addr        = r_addr;
        w_meth_data   = r_q_meth + CNT_W'(1);
        w_unmeth_data = r_q_unmeth + CNT_W'(1);
        if (r_clr_busy) begin
            w_meth_en     = 1'b1;
            w_unmeth_en   = 1'b1;
            w_addr        = r_clr_addr;
            w_meth_data   = '0;
            w_unmeth_data = '0;
        end else if (r_pend) begin
            case (r_op)
                CNT_INC_METH:   w_meth_en   = (r_q_meth != '1);
                CNT_INC_UNMETH: w_unmeth_en = (r_q_unmeth != '1);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_meth_en) begin
            r_meth_mem[w_addr] <= w_meth_data;
        end
        if (w_unmeth_en) begin
            r_unmeth_mem[w_addr] <= w_unmeth_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_q_meth   <= r_meth_mem[i_cmd.addr];
            r_q_unmeth <= r_unmeth_mem[i_cmd.addr];
            r_op       <= i_cmd.op;
            r_addr     <= i_cmd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_pend <= i_cmd.rd;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CNT_AW'(1);
                if (r_clr_addr == CNT_AW'(COUNT_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.clear_busy = r_clr_busy;
    assign o_rsp.meth       = r_q_meth;
    assign o_rsp.unmeth     = r_q_unmeth;

endmodule

@@ design/bisulfite_methylation_caller.sv @@
// Bisulfite methylation caller: read filtering, per-base methylation calls and counting.
// A result is held in r_status with its request, then moves to the output register once that is free.
// A new request is taken only after the one in flight has moved to the output register.
// Reset: synchronous, active low. After reset the counter memories are swept to zero,
// one entry per cycle through all COUNT_DEPTH (65536) entries, and no request is taken meanwhile.
// Configuration writes are taken at any time, also during the sweep.
module bisulfite_methylation_caller import bmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bmc_req_if.sink              i_req,
    bmc_rsp_if.source            o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Configuration registers.
    t_pos  r_region_start;
    t_pos  r_region_end;
    t_qual r_min_mapq;
    t_qual r_min_baseq;

    // State of the open read.
    logic                r_read_active;
    logic                r_read_used;
    logic [STRAND_W-1:0] r_cur_strand;
    logic                r_clip_valid;
    t_pos                r_clip_pos;

    // Request in flight and output register.
    t_state              r_state;
    t_status             r_status;
    logic [STRAND_W-1:0] r_strand;
    logic                r_use_counts;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [STRAND_W-1:0] r_out_strand;
    t_cnt                r_out_meth;
    t_cnt                r_out_unmeth;

    logic                n_read_active;
    logic                n_read_used;
    logic [STRAND_W-1:0] n_cur_strand;
    logic                n_clip_valid;
    t_pos                n_clip_pos;
    t_status             n_status;
    logic [STRAND_W-1:0] n_strand;
    logic                n_use_counts;

    t_cnt_cmd cnt_cmd;
    t_cnt_rsp cnt_rsp;

    logic                accept;
    logic                out_load;
    t_pos                rel_pos;
    logic                in_mem;
    logic                in_region;
    logic                clipped;
    logic                mate_clip;
    t_status             hdr_status;
    logic [STRAND_W-1:0] hdr_strand;
    t_status             base_status;
    t_cnt_op             base_op;

    // Strand class of a read from its flags and its genome conversion tag.
    function automatic logic [STRAND_W-1:0] f_strand(input logic [FLAG_W-1:0] fl,
                                                      input logic [1:0] conv);
        logic                rev;
        logic                r1;
        logic [STRAND_W-1:0] cls;
        rev = fl[FLAG_REVERSE];
        r1  = fl[FLAG_READ1];
        if (conv == CONV_CT) begin
            cls = (rev ^ r1) ? STRAND_3 : STRAND_1;
        end else if (conv == CONV_GA) begin
            cls = (rev ^ r1) ? STRAND_2 : STRAND_4;
        end else if (fl[FLAG_PAIRED]) begin
            if (r1) begin
                cls = rev ? STRAND_2 : STRAND_1;
            end else begin
                cls = (fl[FLAG_READ2] && rev) ? STRAND_1 : STRAND_2;
            end
        end else begin
            cls = rev ? STRAND_2 : STRAND_1;
        end
        return cls;
    endfunction

    assign accept   = i_req.valid && i_req.ready;
    assign out_load = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // Requests are taken only between items and never during the clearing sweep.
    assign i_req.ready = (r_state == S_IDLE) && !cnt_rsp.clear_busy;

    // Window checks shared by bases and readouts. The counter address is the offset
    // from the region start; offsets at or past the memory depth fall outside.
    assign rel_pos   = i_req.ref_position - r_region_start;
    assign in_mem    = (i_req.ref_position >= r_region_start) &&
                       (rel_pos < POS_W'(COUNT_DEPTH));
    assign in_region = in_mem && (i_req.ref_position < r_region_end);
    assign clipped   = r_clip_valid && (i_req.ref_position >= r_clip_pos);

    // A paired read with its mate on the same chromosome is clipped where it overlaps
    // the mate, so that the overlapping bases are counted only once per pair.
    assign mate_clip = i_req.sam_flags[FLAG_PAIRED] && !i_req.sam_flags[FLAG_MUNMAP] &&
                       i_req.mate_same_chrom &&
                       ((i_req.ref_position < i_req.mate_position) ||
                        ((i_req.ref_position == i_req.mate_position) &&
                         i_req.sam_flags[FLAG_READ2]));

    assign hdr_strand = f_strand(i_req.sam_flags, i_req.conversion_tag);

    // Header filter: the first failing check in this order gives the drop reason.
    always_comb begin
        if (i_req.sam_flags[FLAG_UNMAP]) begin
            hdr_status = ST_UNMAPPED;
        end else if (i_req.sam_flags[FLAG_SECONDARY]) begin
            hdr_status = ST_SECONDARY;
        end else if (i_req.sam_flags[FLAG_QCFAIL]) begin
            hdr_status = ST_QC_FAIL;
        end else if (i_req.sam_flags[FLAG_DUP]) begin
            hdr_status = ST_DUPLICATE;
        end else if (i_req.sam_flags[FLAG_SUPPL]) begin
            hdr_status = ST_SUPPLEMENTARY;
        end else if (i_req.map_quality < r_min_mapq) begin
            hdr_status = ST_LOW_MAPQ;
        end else if (i_req.hit_count > 8'd1) begin
            hdr_status = ST_MULTIMAPPED;
        end else begin
            hdr_status = ST_ACCEPTED;
        end
    end

    // Base call. A tag call wins; otherwise a C on the C-to-T strands is called from
    // C versus T in the read, and a G on the G-to-A strands from G versus A.
    always_comb begin
        base_op     = CNT_READ;
        base_status = ST_NO_CALL;
        if (!r_read_active) begin
            base_status = ST_NO_READ;
        end else if (clipped || !in_region) begin
            base_status = (clipped && in_region) ? ST_CLIPPED : ST_OUTSIDE;
        end else if ((i_req.ref_base != REF_C) && (i_req.ref_base != REF_G)) begin
            base_status = ST_NOT_CYT;
        end else if (i_req.base_quality < r_min_baseq) begin
            base_status = ST_LOW_BASEQ;
        end else begin
            if (i_req.meth_tag_call == TAG_METH) begin
                base_op = CNT_INC_METH;
            end else if (i_req.meth_tag_call == TAG_UNMETH) begin
                base_op = CNT_INC_UNMETH;
            end else if ((i_req.ref_base == REF_C) &&
                         ((r_cur_strand == STRAND_1) || (r_cur_strand == STRAND_3))) begin
                if (i_req.read_base == NT_C) begin
                    base_op = CNT_INC_METH;
                end else if (i_req.read_base == NT_T) begin
                    base_op = CNT_INC_UNMETH;
                end
            end else if ((i_req.ref_base == REF_G) &&
                         ((r_cur_strand == STRAND_2) || (r_cur_strand == STRAND_4))) begin
                if (i_req.read_base == NT_G) begin
                    base_op = CNT_INC_METH;
                end else if (i_req.read_base == NT_A) begin
                    base_op = CNT_INC_UNMETH;
                end
            end
            case (base_op)
                CNT_INC_METH:   base_status = ST_METH;
                CNT_INC_UNMETH: base_status = ST_UNMETH;
                default:        base_status = ST_NO_CALL;
            endcase
        end
    end

    // Decode of the accepted request: its status, the read state it leaves behind,
    // and the counter memory access it starts.
    always_comb begin
        n_read_active = r_read_active;
        n_read_used   = r_read_used;
        n_cur_strand  = r_cur_strand;
        n_clip_valid  = r_clip_valid;
        n_clip_pos    = r_clip_pos;
        n_status      = ST_READOUT;
        n_strand      = STRAND_NONE;
        n_use_counts  = 1'b0;
        cnt_cmd.rd    = 1'b0;
        cnt_cmd.op    = CNT_READ;
        cnt_cmd.addr  = rel_pos[CNT_AW-1:0];
        if (accept) begin
            unique case (t_req_type'(i_req.req_type))
                REQ_HEADER: begin
                    // A new header abandons any open read; a dropped one leaves none open.
                    n_status      = hdr_status;
                    n_read_used   = 1'b0;
                    n_read_active = (hdr_status == ST_ACCEPTED);
                    n_cur_strand  = (hdr_status == ST_ACCEPTED) ? hdr_strand : STRAND_NONE;
                    n_strand      = (hdr_status == ST_ACCEPTED) ? hdr_strand : STRAND_NONE;
                    n_clip_valid  = (hdr_status == ST_ACCEPTED) && mate_clip;
                    n_clip_pos    = i_req.mate_position;
                end
                REQ_BASE: begin
                    n_status = base_status;
                    if ((base_op == CNT_INC_METH) || (base_op == CNT_INC_UNMETH)) begin
                        n_read_used = 1'b1;
                        cnt_cmd.rd  = 1'b1;
                        cnt_cmd.op  = base_op;
                    end
                end
                REQ_END: begin
                    n_status      = (r_read_active && r_read_used) ? ST_END_USED
                                                                   : ST_END_UNUSED;
                    n_read_active = 1'b0;
                    n_read_used   = 1'b0;
                end
                REQ_READOUT: begin
                    // Sites outside the memory window read as zero counts.
                    n_status     = ST_READOUT;
                    n_use_counts = in_mem;
                    cnt_cmd.rd   = in_mem;
                end
            endcase
        end
    end

    bmc_count_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cnt_cmd),
        .o_rsp   (cnt_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= '0;
            r_region_end   <= POS_W'(65536);
            r_min_mapq     <= '0;
            r_min_baseq    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_START: r_region_start <= i_cfg_data;
                CFG_REGION_END:   r_region_end   <= i_cfg_data;
                CFG_MIN_MAPQ:     r_min_mapq     <= i_cfg_data[QUAL_W-1:0];
                CFG_MIN_BASEQ:    r_min_baseq    <= i_cfg_data[QUAL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Request sequencer. The decode and the memory read issue at the accept edge;
    // in the execute cycle the read data is valid, the counter is written back and
    // the result moves to the output register once that register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_read_active <= 1'b0;
            r_read_used   <= 1'b0;
            r_cur_strand  <= STRAND_NONE;
            r_clip_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_read_active <= n_read_active;
            r_read_used   <= n_read_used;
            r_cur_strand  <= n_cur_strand;
            r_clip_valid  <= n_clip_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_clip_pos <= n_clip_pos;
        if (accept) begin
            r_status     <= n_status;
            r_strand     <= n_strand;
            r_use_counts <= n_use_counts;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_strand <= r_strand;
            r_out_meth   <= r_use_counts ? cnt_rsp.meth : '0;
            r_out_unmeth <= r_use_counts ? cnt_rsp.unmeth : '0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.read_strand  = r_out_strand;
    assign o_rsp.meth_count   = r_out_meth;
    assign o_rsp.unmeth_count = r_out_unmeth;

`ifndef SYNTHESIS
    // Every accepted request is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // A read can only have contributed a count while it is open.
    a_used_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_used |-> r_read_active)
        else $error("read marked used without an open read");

    // No request is taken while the counter memories are being cleared.
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_rsp.clear_busy |-> !i_req.ready)
        else $error("request taken during clearing sweep");

    // With the output register free, the execute cycle always completes.
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("execute cycle failed to deliver its result");
`endif

endmodule

@@ tb/bisulfite_methylation_caller_tb.sv @@
// Self-checking testbench of the bisulfite methylation caller: directed and random traffic.
module bisulfite_methylation_caller_tb import bmc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no request and no result accepted before the run is declared hung.
    // The counter sweep after reset keeps the input closed while it clears every counter entry.
    localparam int WATCHDOG_LIMIT = 4 * COUNT_DEPTH + 20000;
    // Pause after the last owed result has arrived, to let the block settle.
    localparam int DRAIN_CYCLES   = 4;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int LONG_HOLD      = 300;
    // Number of sites near region_start that random reads concentrate on.
    localparam int HOT_SPAN       = 48;

    // One request as the host would issue it.
    typedef struct {
        t_req_type         kind;
        logic [FLAG_W-1:0] flags;
        t_qual             map_quality;
        logic [7:0]        hit_count;
        logic [1:0]        conversion;
        t_pos              position;
        t_pos              mate_position;
        logic              mate_same_chrom;
        logic [1:0]        ref_base;
        logic [3:0]        read_base;
        t_qual             base_quality;
        logic [1:0]        meth_tag;
    } t_request;

    // One result of the block.
    typedef struct {
        t_status             status;
        logic [STRAND_W-1:0] strand;
        t_cnt                meth;
        t_cnt                unmeth;
    } t_outcome;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_PERIODIC
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bmc_req_if req_ch ();
    bmc_rsp_if rsp_ch ();

    bisulfite_methylation_caller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Shadow of the configuration registers as last written.
    t_pos  cfg_start;
    t_pos  cfg_end;
    t_qual cfg_min_mapq;
    t_qual cfg_min_baseq;

    // Shadow of the caller's own state: the open read and the two counter memories.
    bit                  read_open;
    bit                  read_used;
    logic [STRAND_W-1:0] open_strand;
    logic [31:0]         clip_at;
    bit [CNT_W-1:0]      meth_tally   [COUNT_DEPTH];
    bit [CNT_W-1:0]      unmeth_tally [COUNT_DEPTH];

    // Results still owed by the block, oldest first.
    t_outcome pending_outcomes[$];

    int mismatch_count;
    int items_sent;
    int burst_left;
    bit hold_off_request;

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Bisulfite strand class from the flag word and the genome conversion tag.
    // A conversion tag of 3 is handled as if no tag were present.
    function automatic logic [STRAND_W-1:0] strand_class_of(logic [FLAG_W-1:0] fl,
                                                            logic [1:0] conv);
        logic rev;
        logic r1;
        rev = fl[FLAG_REVERSE];
        r1  = fl[FLAG_READ1];
        if (conv == CONV_CT) begin
            return (rev ^ r1) ? STRAND_3 : STRAND_1;
        end
        if (conv == CONV_GA) begin
            return (rev ^ r1) ? STRAND_2 : STRAND_4;
        end
        if (fl[FLAG_PAIRED]) begin
            if (r1) begin
                return rev ? STRAND_2 : STRAND_1;
            end
            return (fl[FLAG_READ2] && rev) ? STRAND_1 : STRAND_2;
        end
        return rev ? STRAND_2 : STRAND_1;
    endfunction

    // Works out the result of one accepted request and advances the shadow state.
    task automatic methylation_outcome(input t_request it, output t_outcome o);
        logic [31:0] rel;
        logic        in_window;
        logic        past_clip;
        logic        call_meth;
        logic        call_unmeth;
        o.status    = ST_ACCEPTED;
        o.strand    = STRAND_NONE;
        o.meth      = '0;
        o.unmeth    = '0;
        rel         = {1'b0, it.position} - {1'b0, cfg_start};
        call_meth   = 1'b0;
        call_unmeth = 1'b0;
        case (it.kind)
            REQ_HEADER: begin
                // Any header closes the read that was open, without a report.
                read_open   = 1'b0;
                read_used   = 1'b0;
                open_strand = STRAND_NONE;
                clip_at     = '1;
                if (it.flags[FLAG_UNMAP]) begin
                    o.status = ST_UNMAPPED;
                end else if (it.flags[FLAG_SECONDARY]) begin
                    o.status = ST_SECONDARY;
                end else if (it.flags[FLAG_QCFAIL]) begin
                    o.status = ST_QC_FAIL;
                end else if (it.flags[FLAG_DUP]) begin
                    o.status = ST_DUPLICATE;
                end else if (it.flags[FLAG_SUPPL]) begin
                    o.status = ST_SUPPLEMENTARY;
                end else if (it.map_quality < cfg_min_mapq) begin
                    o.status = ST_LOW_MAPQ;
                end else if (it.hit_count > 1) begin
                    o.status = ST_MULTIMAPPED;
                end
                if (o.status == ST_ACCEPTED) begin
                    open_strand = strand_class_of(it.flags, it.conversion);
                    // The leftmost mate of an overlapping pair stops counting where
                    // its mate starts; on a tie the second read yields.
                    if (it.flags[FLAG_PAIRED] && !it.flags[FLAG_MUNMAP] &&
                        it.mate_same_chrom) begin
                        if (it.position < it.mate_position ||
                            (it.position == it.mate_position && it.flags[FLAG_READ2])) begin
                            clip_at = {1'b0, it.mate_position};
                        end
                    end
                    read_open = 1'b1;
                    o.strand  = open_strand;
                end
            end
            REQ_BASE: begin
                in_window = it.position >= cfg_start && it.position < cfg_end &&
                            rel < COUNT_DEPTH;
                past_clip = {1'b0, it.position} >= clip_at;
                if (!read_open) begin
                    o.status = ST_NO_READ;
                end else if (past_clip || !in_window) begin
                    o.status = (past_clip && in_window) ? ST_CLIPPED : ST_OUTSIDE;
                end else if (it.ref_base != REF_C && it.ref_base != REF_G) begin
                    o.status = ST_NOT_CYT;
                end else if (it.base_quality < cfg_min_baseq) begin
                    o.status = ST_LOW_BASEQ;
                end else begin
                    // A methylation tag wins over the converted base.
                    if (it.meth_tag == TAG_METH) begin
                        call_meth = 1'b1;
                    end else if (it.meth_tag == TAG_UNMETH) begin
                        call_unmeth = 1'b1;
                    end else if (it.ref_base == REF_C &&
                                 (open_strand == STRAND_1 || open_strand == STRAND_3)) begin
                        call_meth   = it.read_base == NT_C;
                        call_unmeth = it.read_base == NT_T;
                    end else if (it.ref_base == REF_G &&
                                 (open_strand == STRAND_2 || open_strand == STRAND_4)) begin
                        call_meth   = it.read_base == NT_G;
                        call_unmeth = it.read_base == NT_A;
                    end
                    // Counters saturate at all ones.
                    if (call_meth) begin
                        if (meth_tally[rel[CNT_AW-1:0]] != '1) begin
                            meth_tally[rel[CNT_AW-1:0]]++;
                        end
                        read_used = 1'b1;
                        o.status  = ST_METH;
                    end else if (call_unmeth) begin
                        if (unmeth_tally[rel[CNT_AW-1:0]] != '1) begin
                            unmeth_tally[rel[CNT_AW-1:0]]++;
                        end
                        read_used = 1'b1;
                        o.status  = ST_UNMETH;
                    end else begin
                        o.status = ST_NO_CALL;
                    end
                end
            end
            REQ_END: begin
                o.status  = (read_open && read_used) ? ST_END_USED : ST_END_UNUSED;
                read_open = 1'b0;
                read_used = 1'b0;
            end
            default: begin
                // Readout ignores region_end; only region_start and the memory depth bound it.
                o.status = ST_READOUT;
                if (it.position >= cfg_start && rel < COUNT_DEPTH) begin
                    o.meth   = meth_tally[rel[CNT_AW-1:0]];
                    o.unmeth = unmeth_tally[rel[CNT_AW-1:0]];
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    // Every field random, so that bits the request kind ignores still toggle.
    function automatic t_request noise_request();
        t_request r;
        r.kind            = t_req_type'($urandom_range(0, 3));
        r.flags           = FLAG_W'($urandom);
        r.map_quality     = t_qual'($urandom);
        r.hit_count       = 8'($urandom);
        r.conversion      = 2'($urandom);
        r.position        = t_pos'($urandom);
        r.mate_position   = t_pos'($urandom);
        r.mate_same_chrom = 1'($urandom);
        r.ref_base        = 2'($urandom);
        r.read_base       = 4'($urandom);
        r.base_quality    = t_qual'($urandom);
        r.meth_tag        = 2'($urandom);
        return r;
    endfunction

    function automatic t_request header_of(logic [FLAG_W-1:0] fl, logic [1:0] conv,
                                           t_pos pos, t_pos mate, logic same,
                                           t_qual mapq, logic [7:0] hits);
        t_request r;
        r                 = noise_request();
        r.kind            = REQ_HEADER;
        r.flags           = fl;
        r.conversion      = conv;
        r.position        = pos;
        r.mate_position   = mate;
        r.mate_same_chrom = same;
        r.map_quality     = mapq;
        r.hit_count       = hits;
        return r;
    endfunction

    function automatic t_request base_at(t_pos pos, logic [1:0] ref_nt, logic [3:0] read_nt,
                                         t_qual qual, logic [1:0] tag);
        t_request r;
        r              = noise_request();
        r.kind         = REQ_BASE;
        r.position     = pos;
        r.ref_base     = ref_nt;
        r.read_base    = read_nt;
        r.base_quality = qual;
        r.meth_tag     = tag;
        return r;
    endfunction

    function automatic t_request plain_request(t_req_type kind, t_pos pos);
        t_request r;
        r          = noise_request();
        r.kind     = kind;
        r.position = pos;
        return r;
    endfunction

    // A site in the small window just above region_start, where counts pile up.
    function automatic t_pos hot_site();
        return t_pos'(cfg_start + $urandom_range(0, HOT_SPAN - 1));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one request and waits until the block takes it. The sender runs in
    // bursts; when a burst is used up, valid drops for a random gap first.
    task automatic send_request(input t_request it);
        t_outcome want;
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= it.kind;
        req_ch.sam_flags       <= it.flags;
        req_ch.map_quality     <= it.map_quality;
        req_ch.hit_count       <= it.hit_count;
        req_ch.conversion_tag  <= it.conversion;
        req_ch.ref_position    <= it.position;
        req_ch.mate_position   <= it.mate_position;
        req_ch.mate_same_chrom <= it.mate_same_chrom;
        req_ch.ref_base        <= it.ref_base;
        req_ch.read_base       <= it.read_base;
        req_ch.base_quality    <= it.base_quality;
        req_ch.meth_tag_call   <= it.meth_tag;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        methylation_outcome(it, want);
        pending_outcomes.push_back(want);
        burst_left--;
        items_sent++;
    endtask

    // Lets every owed result arrive, then gives the block time to settle.
    task automatic wait_drained();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_REGION_START: cfg_start     = data;
            CFG_REGION_END:   cfg_end       = data;
            CFG_MIN_MAPQ:     cfg_min_mapq  = data[QUAL_W-1:0];
            default:          cfg_min_baseq = data[QUAL_W-1:0];
        endcase
    endtask

    // Registers change only with the block idle. The quality registers are
    // written with junk above bit 7, which the block must ignore.
    task automatic set_config(input t_pos start, input t_pos stop,
                              input t_qual mapq, input t_qual baseq);
        logic [CFG_W-1:0] junk;
        req_ch.valid <= 1'b0;
        wait_drained();
        junk = CFG_W'($urandom);
        write_reg(CFG_REGION_START, start);
        write_reg(CFG_REGION_END, stop);
        write_reg(CFG_MIN_MAPQ, {junk[CFG_W-1:QUAL_W], mapq});
        junk = CFG_W'($urandom);
        write_reg(CFG_MIN_BASEQ, {junk[CFG_W-1:QUAL_W], baseq});
    endtask

    // One well-formed read with random content: a header that mostly passes the
    // filters, a run of bases near its start, usually a read end, and now and
    // then a readout, mostly of a site near region_start.
    task automatic send_random_read();
        t_request it;
        t_request hdr;
        t_pos     walk;
        int       n_bases;
        int       pick;
        hdr = noise_request();
        hdr.kind = REQ_HEADER;
        if ($urandom_range(0, 15) == 0) begin
            hdr.flags = FLAG_W'($urandom);
        end else begin
            hdr.flags = '0;
            hdr.flags[FLAG_PAIRED] = 1'($urandom_range(0, 1));
            if (hdr.flags[FLAG_PAIRED]) begin
                if ($urandom_range(0, 1)) begin
                    hdr.flags[FLAG_READ1] = 1'b1;
                end else begin
                    hdr.flags[FLAG_READ2] = 1'b1;
                end
                hdr.flags[FLAG_MUNMAP] = $urandom_range(0, 7) == 0;
            end
            hdr.flags[FLAG_REVERSE] = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                pick = $urandom_range(0, 4);
                hdr.flags[pick == 0 ? FLAG_UNMAP : FLAG_SECONDARY + pick - 1] = 1'b1;
            end
        end
        hdr.map_quality = ($urandom_range(0, 4) != 0) ?
                          t_qual'($urandom_range(cfg_min_mapq, 255)) :
                          t_qual'($urandom_range(0, 255));
        pick = $urandom_range(0, 7);
        hdr.hit_count = (pick < 3) ? 8'd0 : (pick < 6) ? 8'd1 : 8'($urandom_range(0, 255));
        hdr.conversion = 2'($urandom_range(0, 3));
        hdr.position   = hot_site();
        case ($urandom_range(0, 3))
            0:       hdr.mate_position = hdr.position;
            1:       hdr.mate_position = t_pos'(hdr.position + $urandom_range(1, 20));
            2:       hdr.mate_position = t_pos'(hdr.position - $urandom_range(0, 10));
            default: hdr.mate_position = t_pos'($urandom);
        endcase
        hdr.mate_same_chrom = $urandom_range(0, 4) != 0;
        send_request(hdr);

        walk    = hdr.position;
        n_bases = $urandom_range(0, 10);
        repeat (n_bases) begin
            it = noise_request();
            it.kind = REQ_BASE;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                it.position = t_pos'($urandom);
            end else if (pick == 1) begin
                // Around the end of the counter memory.
                it.position = t_pos'(cfg_start + $urandom_range(COUNT_DEPTH - 3,
                                                                COUNT_DEPTH + 3));
            end else if (pick == 2) begin
                it.position = t_pos'(cfg_start - $urandom_range(1, 3));
            end else begin
                walk = t_pos'(walk + $urandom_range(0, 3));
                it.position = walk;
            end
            pick = $urandom_range(0, 9);
            it.ref_base = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 :
                          ($urandom_range(0, 1) ? REF_C : REF_G);
            pick = $urandom_range(0, 4);
            if (it.ref_base == REF_C && pick < 4) begin
                it.read_base = (pick < 2) ? NT_C : NT_T;
            end else if (it.ref_base == REF_G && pick < 4) begin
                it.read_base = (pick < 2) ? NT_G : NT_A;
            end
            it.base_quality = ($urandom_range(0, 4) != 0) ?
                              t_qual'($urandom_range(cfg_min_baseq, 255)) :
                              t_qual'($urandom_range(0, 255));
            it.meth_tag = ($urandom_range(0, 9) < 7) ? 2'd0 : 2'($urandom_range(1, 3));
            send_request(it);
        end

        if ($urandom_range(0, 19) < 17) begin
            send_request(plain_request(REQ_END, t_pos'($urandom)));
        end
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
            send_request(plain_request(REQ_READOUT, hot_site()));
        end else if (pick == 7) begin
            send_request(plain_request(REQ_READOUT, t_pos'($urandom)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The memories are swept to zero after reset; the first readout waits for it.
    task automatic test_counter_clear();
        set_config(t_pos'(100), t_pos'(1100), t_qual'(20), t_qual'(20));
        send_request(plain_request(REQ_READOUT, t_pos'(100)));
        send_request(plain_request(REQ_READOUT, t_pos'(0)));
    endtask

    // Each drop reason in turn, ending with the two that depend on numbers.
    task automatic test_header_filters();
        logic [FLAG_W-1:0] fl;
        foreach (fl[i]) fl[i] = 1'b0;
        fl[FLAG_UNMAP] = 1'b1;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd60, 8'd1));
        fl = '0; fl[FLAG_SECONDARY] = 1'b1;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd60, 8'd1));
        fl = '0; fl[FLAG_QCFAIL] = 1'b1;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd60, 8'd1));
        fl = '0; fl[FLAG_DUP] = 1'b1;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd60, 8'd1));
        fl = '0; fl[FLAG_SUPPL] = 1'b1;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd60, 8'd1));
        send_request(header_of('0, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd19, 8'd1));
        send_request(header_of('0, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd60, 8'd2));
    endtask

    // Bases and read ends with and without an open read, through every outcome.
    task automatic test_base_calls();
        logic [FLAG_W-1:0] fl;
        send_request(base_at(t_pos'(102), REF_C, NT_C, 8'd60, 2'd0));
        send_request(plain_request(REQ_END, t_pos'(0)));
        // Paired first read on the reverse strand, no conversion tag: class 2.
        // Its mate starts at 110, so counting stops there.
        fl = '0;
        fl[FLAG_PAIRED]  = 1'b1;
        fl[FLAG_READ1]   = 1'b1;
        fl[FLAG_REVERSE] = 1'b1;
        send_request(header_of(fl, 2'd0, t_pos'(100), t_pos'(110), 1'b1, 8'd20, 8'd1));
        send_request(base_at(t_pos'(99), REF_C, NT_C, 8'd60, 2'd0));
        send_request(base_at(t_pos'(110), REF_G, NT_G, 8'd60, 2'd0));
        send_request(base_at(t_pos'(101), 2'd0, NT_C, 8'd60, 2'd0));
        send_request(base_at(t_pos'(102), REF_G, NT_A, 8'd19, 2'd0));
        send_request(base_at(t_pos'(102), REF_G, NT_A, 8'd20, 2'd0));
        send_request(base_at(t_pos'(103), REF_C, NT_C, 8'd255, 2'd0));
        send_request(base_at(t_pos'(103), REF_C, NT_T, 8'd255, TAG_METH));
        send_request(plain_request(REQ_END, t_pos'(0)));
    endtask

    // Tagged strand classes; each header abandons the read before it, and the
    // last read closes without having counted anything.
    task automatic test_strand_classes();
        logic [FLAG_W-1:0] fl;
        fl = '0;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd255, 8'd0));
        fl[FLAG_REVERSE] = 1'b1;
        send_request(header_of(fl, CONV_CT, t_pos'(100), t_pos'(0), 1'b0, 8'd255, 8'd0));
        send_request(header_of('0, CONV_GA, t_pos'(100), t_pos'(0), 1'b0, 8'd255, 8'd1));
        send_request(plain_request(REQ_END, t_pos'(0)));
        send_request(plain_request(REQ_READOUT, t_pos'(102)));
        send_request(plain_request(REQ_READOUT, t_pos'(103)));
    endtask

    // Random reads under one register setting until the running total reaches goal.
    task automatic test_random_traffic(input t_pos start, input t_pos stop,
                                       input t_qual mapq, input t_qual baseq,
                                       input int goal);
        set_config(start, stop, mapq, baseq);
        while (items_sent < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(noise_request());
            end else begin
                send_random_read();
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers
    // requests back to back, so the block fills up and closes its input.
    task automatic test_backpressure();
        burst_left       = 1000000;
        hold_off_request = 1'b1;
        repeat (4) send_random_read();
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern, checker and watchdog
    // ------------------------------------------------------------------

    // The receiver keeps each stall pattern for a random run before picking the next:
    // always ready, random, sparse or a fixed rhythm.
    initial begin : rsp_stall_gen
        t_stall_mode mode;
        int          mode_left;
        int          beat;
        mode      = STALL_NONE;
        mode_left = 0;
        beat      = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 400);
                end
                mode_left--;
                beat++;
                case (mode)
                    STALL_NONE:   rsp_ch.ready <= 1'b1;
                    STALL_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    STALL_SPARSE: rsp_ch.ready <= $urandom_range(0, 3) == 0;
                    default:      rsp_ch.ready <= (beat % 5) < 3;
                endcase
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    // Each accepted result is held against the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_outcomes
        t_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, got status %0d",
                         $time, rsp_ch.status);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.status !== want.status) begin
                    report_mismatch("status", want.status, rsp_ch.status);
                end
                if (rsp_ch.read_strand !== want.strand) begin
                    report_mismatch("read_strand", want.strand, rsp_ch.read_strand);
                end
                if (rsp_ch.meth_count !== want.meth) begin
                    report_mismatch("meth_count", want.meth, rsp_ch.meth_count);
                end
                if (rsp_ch.unmeth_count !== want.unmeth) begin
                    report_mismatch("unmeth_count", want.unmeth, rsp_ch.unmeth_count);
                end
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    initial begin : hang_watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_REGION_START;
        i_cfg_data <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.req_type        <= REQ_HEADER;
        req_ch.sam_flags       <= '0;
        req_ch.map_quality     <= '0;
        req_ch.hit_count       <= '0;
        req_ch.conversion_tag  <= '0;
        req_ch.ref_position    <= '0;
        req_ch.mate_position   <= '0;
        req_ch.mate_same_chrom <= 1'b0;
        req_ch.ref_base        <= '0;
        req_ch.read_base       <= '0;
        req_ch.base_quality    <= '0;
        req_ch.meth_tag_call   <= '0;

        // Shadow state as it stands after reset.
        cfg_start        = '0;
        cfg_end          = t_pos'(COUNT_DEPTH);
        cfg_min_mapq     = '0;
        cfg_min_baseq    = '0;
        read_open        = 1'b0;
        read_used        = 1'b0;
        open_strand      = STRAND_NONE;
        clip_at          = '1;
        mismatch_count   = 0;
        items_sent       = 0;
        burst_left       = 0;
        hold_off_request = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_counter_clear();
        test_header_filters();
        test_base_calls();
        test_strand_classes();

        // Register settings from the plain defaults to the extremes: a region
        // at the very top of the position range with the strictest qualities,
        // an empty region, and one wider than the counter memory.
        test_random_traffic(t_pos'(0), t_pos'(COUNT_DEPTH), t_qual'(0), t_qual'(0), 420);
        test_random_traffic(t_pos'(1000), t_pos'(1000 + COUNT_DEPTH),
                            t_qual'($urandom_range(1, 60)), t_qual'($urandom_range(1, 40)),
                            800);
        test_backpressure();
        test_random_traffic(t_pos'('1) - t_pos'(40), '1, t_qual'(255), t_qual'(255), 1180);
        test_random_traffic(t_pos'(5000), t_pos'(0),
                            t_qual'($urandom_range(0, 255)), t_qual'($urandom_range(0, 255)),
                            1560);
        test_random_traffic(t_pos'(300), '1, t_qual'(10), t_qual'(0), 1975);

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ bisulfite_methylation_caller.f @@
design/bmc_pkg.sv
design/bmc_req_if.sv
design/bmc_rsp_if.sv
design/bmc_count_store.sv
design/bisulfite_methylation_caller.sv
tb/bisulfite_methylation_caller_tb.sv
